FILE: rtl/ntlv_pkg.sv
`default_nettype none

package ntlv_pkg;

  localparam int POS_W  = 10;
  localparam int LEN_W  = 9;
  localparam int RLEN_W = 32;
  localparam int TLEN_W = 8;
  localparam int FBL_W  = 3;

  localparam logic [7:0] TAG_NDEF    = 8'h03;
  localparam logic [7:0] LEN_ESCAPE  = 8'hFF;
  localparam logic [7:0] OPEN_BRACE  = 8'h7B;
  localparam logic [7:0] CLOSE_BRACE = 8'h7D;
  localparam int         SR_BIT      = 4;

  localparam logic [FBL_W-1:0] PLEN_SHORT_BYTES = 3'd1;
  localparam logic [FBL_W-1:0] PLEN_LONG_BYTES  = 3'd4;

  localparam logic [POS_W-1:0]  MIN_DUMP_BYTES = 10'd5;
  localparam logic [POS_W-1:0]  END_SLACK      = 10'd10;
  localparam logic [RLEN_W-1:0] MIN_REC_LEN    = 32'd2;
  localparam logic [LEN_W-1:0]  LEN_SAT        = 9'd511;

  typedef enum logic [2:0] {
    PH_SEARCH,
    PH_LEN,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_HEADER,
    PH_TYPELEN,
    PH_PLEN,
    PH_DONE
  } phase_t;

  // State of one dump as seen after its final byte
  typedef struct packed {
    logic [POS_W-1:0]  count;
    logic              done;
    logic [POS_W-1:0]  rec_start;
    logic [RLEN_W-1:0] rec_len;
    logic              open_seen;
    logic              close_seen;
    logic [POS_W-1:0]  first_open;
    logic [POS_W-1:0]  last_close;
  } snap_t;

  typedef struct packed {
    logic             found;
    logic             method;
    logic [POS_W-1:0] start;
    logic [LEN_W-1:0] length;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/ndef_tlv_payload_locator.sv
// Locates the payload of the first NDEF message TLV in a tag memory dump
// fed one byte per transaction, with in_last_byte on the final byte. One
// byte is taken every cycle unless in_stall is high. The parse state updates
// as each byte is accepted; the final byte latches a snapshot, from which
// the result register is loaded once the output is not stalled, and a new
// dump may start in the cycle after its final byte unless in_stall holds it.
// If the TLV span does not qualify, the span from the first '{' to the last
// '}' is reported (out_method = 1). Bytes beyond MAX_BYTES are ignored except
// for the final mark. in_stall rises only while a snapshot and a result both
// wait behind out_stall.
`default_nettype none

module ndef_tlv_payload_locator
  import ntlv_pkg::*;
#(
  parameter int MAX_BYTES = 256
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_last_byte,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  out_found,
  output logic                  out_method,
  output logic [POS_W-1:0]      out_payload_start,
  output logic [LEN_W-1:0]      out_payload_length
);

  localparam int CNT_W = $clog2(MAX_BYTES + 1);

  logic [CNT_W-1:0]  count_r, count_nxt;
  phase_t            phase_r, phase_nxt;
  logic [FBL_W-1:0]  fbl_r, fbl_nxt;
  logic              short_r, short_nxt;
  logic [TLEN_W-1:0] tlen_r, tlen_nxt;
  logic [RLEN_W-1:0] rlen_r, rlen_nxt;
  logic [POS_W-1:0]  rstart_r, rstart_nxt;
  logic [POS_W-1:0]  first_open_r, first_open_nxt;
  logic              open_seen_r, open_seen_nxt;
  logic [POS_W-1:0]  last_close_r, last_close_nxt;
  logic              close_seen_r, close_seen_nxt;

  logic              in_fire;
  logic              active;
  logic [CNT_W-1:0]  count_inc;
  logic [FBL_W-1:0]  fbl_dec;

  snap_t             snap_r, snap_now;
  logic              snap_v_r;
  logic              snap_adv;
  res_t              res;

  assign in_stall  = snap_v_r && out_valid && out_stall;
  assign in_fire   = in_valid && !in_stall;
  assign active    = count_r < CNT_W'(MAX_BYTES);
  assign count_inc = count_r + CNT_W'(1);
  assign fbl_dec   = (fbl_r != '0) ? fbl_r - FBL_W'(1) : fbl_r;

  always_comb begin
    count_nxt      = count_r;
    phase_nxt      = phase_r;
    fbl_nxt        = fbl_r;
    short_nxt      = short_r;
    tlen_nxt       = tlen_r;
    rlen_nxt       = rlen_r;
    rstart_nxt     = rstart_r;
    first_open_nxt = first_open_r;
    open_seen_nxt  = open_seen_r;
    last_close_nxt = last_close_r;
    close_seen_nxt = close_seen_r;
    if (in_fire && active) begin
      count_nxt = count_inc;
      if (in_data_byte == OPEN_BRACE && !open_seen_r) begin
        first_open_nxt = POS_W'(count_r);
        open_seen_nxt  = 1'b1;
      end
      if (in_data_byte == CLOSE_BRACE) begin
        last_close_nxt = POS_W'(count_r);
        close_seen_nxt = 1'b1;
      end
      unique case (phase_r)
        PH_SEARCH: begin
          if (in_data_byte == TAG_NDEF) phase_nxt = PH_LEN;
        end
        PH_LEN: begin
          phase_nxt = (in_data_byte == LEN_ESCAPE) ? PH_LEN_HI : PH_HEADER;
        end
        PH_LEN_HI: phase_nxt = PH_LEN_LO;
        PH_LEN_LO: phase_nxt = PH_HEADER;
        PH_HEADER: begin
          short_nxt = in_data_byte[SR_BIT];
          phase_nxt = PH_TYPELEN;
        end
        PH_TYPELEN: begin
          tlen_nxt  = in_data_byte;
          fbl_nxt   = short_r ? PLEN_SHORT_BYTES : PLEN_LONG_BYTES;
          rlen_nxt  = '0;
          phase_nxt = PH_PLEN;
        end
        PH_PLEN: begin
          rlen_nxt = {rlen_r[RLEN_W-9:0], in_data_byte};
          fbl_nxt  = fbl_dec;
          if (fbl_dec == '0) begin
            rstart_nxt = POS_W'(count_inc) + POS_W'(tlen_r);
            phase_nxt  = PH_DONE;
          end
        end
        PH_DONE: phase_nxt = PH_DONE;
        default: phase_nxt = PH_SEARCH;
      endcase
    end
  end

  always_comb begin
    snap_now.count      = POS_W'(count_nxt);
    snap_now.done       = (phase_nxt == PH_DONE);
    snap_now.rec_start  = rstart_nxt;
    snap_now.rec_len    = rlen_nxt;
    snap_now.open_seen  = open_seen_nxt;
    snap_now.close_seen = close_seen_nxt;
    snap_now.first_open = first_open_nxt;
    snap_now.last_close = last_close_nxt;
  end

  // Parse state; clear after the final byte so the next dump starts fresh
  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_last_byte)) begin
      count_r      <= '0;
      phase_r      <= PH_SEARCH;
      fbl_r        <= '0;
      short_r      <= 1'b0;
      tlen_r       <= '0;
      rlen_r       <= '0;
      rstart_r     <= '0;
      first_open_r <= '0;
      open_seen_r  <= 1'b0;
      last_close_r <= '0;
      close_seen_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      phase_r      <= phase_nxt;
      fbl_r        <= fbl_nxt;
      short_r      <= short_nxt;
      tlen_r       <= tlen_nxt;
      rlen_r       <= rlen_nxt;
      rstart_r     <= rstart_nxt;
      first_open_r <= first_open_nxt;
      open_seen_r  <= open_seen_nxt;
      last_close_r <= last_close_nxt;
      close_seen_r <= close_seen_nxt;
    end
  end

  assign snap_adv = snap_v_r && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      snap_v_r <= 1'b0;
    end else if (in_fire && in_last_byte) begin
      snap_v_r <= 1'b1;
    end else if (snap_adv) begin
      snap_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && in_last_byte) begin
      snap_r <= snap_now;
    end
  end

  ntlv_decide u_decide (
    .snap (snap_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (snap_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (snap_adv) begin
      out_found          <= res.found;
      out_method         <= res.method;
      out_payload_start  <= res.start;
      out_payload_length <= res.length;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (snap_v_r && out_valid && out_stall))
    else $error("input stalled while a result slot is free");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_last_byte) |=> (count_r == '0 && phase_r == PH_SEARCH && !open_seen_r))
    else $error("parse state not cleared after final byte");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_BYTES))
    else $error("byte count past limit");

  a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (!out_method && out_payload_length == '0 &&
                                   out_payload_start == '0))
    else $error("nonzero fields on a failed result");

  a_snap_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    snap_adv |=> out_valid)
    else $error("snapshot moved without a result");

endmodule

`default_nettype wire

FILE: rtl/ntlv_decide.sv
`default_nettype none

module ntlv_decide
  import ntlv_pkg::*;
(
  input  snap_t snap,
  output res_t  res
);

  logic [RLEN_W:0]  tlv_end;
  logic [RLEN_W:0]  tlv_limit;
  logic             tlv_ok;
  logic             brace_ok;
  logic [POS_W-1:0] span;
  logic [POS_W:0]   span_len;

  assign tlv_end   = (RLEN_W+1)'(snap.rec_start) + {1'b0, snap.rec_len};
  assign tlv_limit = (RLEN_W+1)'(snap.count) + (RLEN_W+1)'(END_SLACK);
  assign tlv_ok    = snap.done && (tlv_end <= tlv_limit) && (snap.rec_len > MIN_REC_LEN);

  assign brace_ok  = snap.open_seen && snap.close_seen && (snap.last_close > snap.first_open);
  assign span      = snap.last_close - snap.first_open;
  assign span_len  = {1'b0, span} + (POS_W+1)'(1);

  always_comb begin
    res = '0;
    if (snap.count >= MIN_DUMP_BYTES) begin
      priority if (tlv_ok) begin
        res.found  = 1'b1;
        res.method = 1'b0;
        res.start  = snap.rec_start;
        res.length = (|snap.rec_len[RLEN_W-1:LEN_W]) ? LEN_SAT : snap.rec_len[LEN_W-1:0];
      end else if (brace_ok) begin
        res.found  = 1'b1;
        res.method = 1'b1;
        res.start  = snap.first_open;
        res.length = (|span_len[POS_W:LEN_W]) ? LEN_SAT : span_len[LEN_W-1:0];
      end else begin
        res = '0;
      end
    end
  end

endmodule

`default_nettype wire
